// ===== design/skdr_pkg.sv =====
// Package for the sparse key to dense id remapper.
// Sizes, state encoding, table access structs and the link to address helper; no dependencies.
package skdr_pkg;

   localparam int BUCKETS  = 128;   // power of two, bucket is the low key bits
   localparam int CAPACITY = 1024;

   localparam int IDX_W  = 31;
   localparam int BASE_W = 16;
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int LINK_W = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1);
   localparam logic [LINK_W-1:0] LINK_NONE  = '0;
   localparam logic [LINK_W-1:0] POOL_FULL  = LINK_W'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_WALK,
      ST_MISS,
      ST_LINK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              head_rd;
      logic              head_wr;
      logic [BKT_W-1:0]  bucket;
      logic [LINK_W-1:0] head_data;
      logic              ent_rd;
      logic [ADDR_W-1:0] ent_addr;
      logic              key_wr;
      logic [ADDR_W-1:0] key_addr;
      logic [IDX_W-1:0]  key_data;
      logic              next_wr;
      logic [ADDR_W-1:0] next_addr;
      logic [LINK_W-1:0] next_data;
   } tbl_req_type;

   typedef struct packed {
      logic [LINK_W-1:0] head_link;
      logic [IDX_W-1:0]  ent_key;
      logic [LINK_W-1:0] ent_next;
   } tbl_rsp_type;

   // link is pool position + 1; zero never reaches here
   function automatic logic [ADDR_W-1:0] link_to_addr(input logic [LINK_W-1:0] link);
      logic [LINK_W-1:0] pos;
      pos = link - LINK_W'(1);
      return pos[ADDR_W-1:0];
   endfunction

endpackage

// ===== design/sparse_key_dense_id_remapper_top.sv =====
// Top level of the sparse key to dense id remapper: control sequencer and output register.
// Uses skdr_pkg and skdr_tables.
//
// One request is handled at a time. A pass-through request (index zero, or key below
// base_count) goes from ST_IDLE straight to ST_RESP. A table lookup passes through ST_HEAD,
// one ST_WALK step per chain entry visited and then ST_RESP on a hit, or ST_MISS and then
// ST_RESP on a miss. The walk reads one pool entry per cycle from the entry memories;
// an insert at the tail of a non-empty chain adds ST_LINK for the link write. A lookup
// response becomes valid in the same cycle in which the next request can be taken. A new
// request is taken while the previous response
// still waits in the output register. base_count may be written at any time the block
// is idle; csr_ready is always high.
module sparse_key_dense_id_remapper_top
   import skdr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [IDX_W-1:0]  req_deh_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_translated_index,
   output logic              rsp_newly_assigned,
   output logic              rsp_table_full,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BASE_W-1:0] csr_base_count
);

   state_type state_ff, state_in;

   logic [BASE_W-1:0] base_ff;
   logic [IDX_W-1:0]  key_ff, key_in;
   logic [LINK_W-1:0] link_ff, link_in;
   logic [LINK_W-1:0] last_ff, last_in;
   logic [LINK_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic              res_new_ff, res_new_in;
   logic              res_full_ff, res_full_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic              rsp_new_ff;
   logic              rsp_full_ff;

   tbl_req_type tbl_req;
   tbl_rsp_type tbl_rsp;

   logic [IDX_W-1:0] req_key;
   logic             req_zero;
   logic             req_pass;
   logic             key_hit;
   logic             out_free;

   assign req_key  = req_deh_index - IDX_W'(1);
   assign req_zero = (req_deh_index == '0);
   assign req_pass = (req_key < IDX_W'(base_ff));
   assign key_hit  = (tbl_rsp.ent_key == key_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   skdr_tables u_tables (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_zero || req_pass) ? ST_RESP : ST_HEAD;
            end
         end
         ST_HEAD: begin
            state_in = (tbl_rsp.head_link == LINK_NONE) ? ST_MISS : ST_WALK;
         end
         ST_WALK: begin
            if (key_hit) begin
               state_in = ST_RESP;
            end else if (tbl_rsp.ent_next == LINK_NONE) begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            if (count_ff == POOL_FULL || last_ff == LINK_NONE) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and table requests
   always_comb begin
      req_ready   = 1'b0;
      tbl_req     = '0;
      key_in      = key_ff;
      link_in     = link_ff;
      last_in     = last_ff;
      count_in    = count_ff;
      res_idx_in  = res_idx_ff;
      res_new_in  = res_new_ff;
      res_full_in = res_full_ff;
      tbl_req.bucket = key_ff[BKT_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            key_in         = req_key;
            tbl_req.bucket = req_key[BKT_W-1:0];
            tbl_req.head_rd = req_valid && !req_zero && !req_pass;
            res_idx_in     = req_zero ? '0 : req_deh_index;
            res_new_in     = 1'b0;
            res_full_in    = 1'b0;
         end
         ST_HEAD: begin
            link_in          = tbl_rsp.head_link;
            last_in          = LINK_NONE;
            tbl_req.ent_rd   = (tbl_rsp.head_link != LINK_NONE);
            tbl_req.ent_addr = link_to_addr(tbl_rsp.head_link);
         end
         ST_WALK: begin
            if (key_hit) begin
               res_idx_in = IDX_W'(base_ff) + IDX_W'(link_ff);
            end else begin
               last_in          = link_ff;
               link_in          = tbl_rsp.ent_next;
               tbl_req.ent_rd   = (tbl_rsp.ent_next != LINK_NONE);
               tbl_req.ent_addr = link_to_addr(tbl_rsp.ent_next);
            end
         end
         ST_MISS: begin
            if (count_ff == POOL_FULL) begin
               res_idx_in  = '0;
               res_full_in = 1'b1;
            end else begin
               tbl_req.key_wr    = 1'b1;
               tbl_req.key_addr  = count_ff[ADDR_W-1:0];
               tbl_req.key_data  = key_ff;
               tbl_req.next_wr   = 1'b1;
               tbl_req.next_addr = count_ff[ADDR_W-1:0];
               tbl_req.next_data = LINK_NONE;
               tbl_req.head_wr   = (last_ff == LINK_NONE);
               tbl_req.head_data = count_ff + LINK_W'(1);
               res_idx_in        = IDX_W'(base_ff) + IDX_W'(count_ff) + IDX_W'(1);
               res_new_in        = 1'b1;
               count_in          = count_ff + LINK_W'(1);
            end
         end
         ST_LINK: begin
            // count already points past the new entry, i.e. its link value
            tbl_req.next_wr   = 1'b1;
            tbl_req.next_addr = link_to_addr(last_ff);
            tbl_req.next_data = count_ff;
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_RESP && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         base_ff      <= BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            base_ff <= csr_base_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      link_ff     <= link_in;
      last_ff     <= last_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
      if (state_ff == ST_RESP && out_free) begin
         rsp_idx_ff  <= res_idx_ff;
         rsp_new_ff  <= res_new_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_translated_index = rsp_idx_ff;
   assign rsp_newly_assigned   = rsp_new_ff;
   assign rsp_table_full       = rsp_full_ff;

endmodule

// ===== design/skdr_tables.sv =====
// Bucket head memory with per-bucket valid bits, and the entry pool memories.
// Uses skdr_pkg for sizes and the request/response structs.
module skdr_tables
   import skdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tbl_req_type tbl_req,
   output tbl_rsp_type tbl_rsp
);

   logic [LINK_W-1:0] head_mem [BUCKETS];
   logic [IDX_W-1:0]  key_mem  [CAPACITY];
   logic [LINK_W-1:0] next_mem [CAPACITY];

   logic [BUCKETS-1:0] head_vld_ff;
   logic               head_q_vld_ff;
   logic [LINK_W-1:0]  head_q_ff;
   logic [IDX_W-1:0]   key_q_ff;
   logic [LINK_W-1:0]  next_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
      end else if (tbl_req.head_wr) begin
         head_vld_ff[tbl_req.bucket] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.head_wr) begin
         head_mem[tbl_req.bucket] <= tbl_req.head_data;
      end
      if (tbl_req.head_rd) begin
         head_q_ff     <= head_mem[tbl_req.bucket];
         head_q_vld_ff <= head_vld_ff[tbl_req.bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.key_wr) begin
         key_mem[tbl_req.key_addr] <= tbl_req.key_data;
      end
      if (tbl_req.ent_rd) begin
         key_q_ff <= key_mem[tbl_req.ent_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.next_wr) begin
         next_mem[tbl_req.next_addr] <= tbl_req.next_data;
      end
      if (tbl_req.ent_rd) begin
         next_q_ff <= next_mem[tbl_req.ent_addr];
      end
   end

   assign tbl_rsp.head_link = head_q_vld_ff ? head_q_ff : LINK_NONE;
   assign tbl_rsp.ent_key   = key_q_ff;
   assign tbl_rsp.ent_next  = next_q_ff;

endmodule

// ===== design/skdr_checker.sv =====
// Port-level checks for the remapper top level, attached by bind.
// Uses skdr_pkg for field widths.
module skdr_checker
   import skdr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [IDX_W-1:0] rsp_translated_index,
   input logic             rsp_newly_assigned,
   input logic             rsp_table_full
);

   logic [1:0] pend_ff, pend_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer && pend_ff != 2'd3) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer && pend_ff != 2'd0) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_translated_index)
         && $stable(rsp_newly_assigned) && $stable(rsp_table_full))
      else $error("response changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests in flight");

   a_full_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_translated_index == '0 && !rsp_newly_assigned)
      else $error("table full response carries an index");

endmodule

bind sparse_key_dense_id_remapper_top skdr_checker u_skdr_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_translated_index (rsp_translated_index),
   .rsp_newly_assigned   (rsp_newly_assigned),
   .rsp_table_full       (rsp_table_full)
);
